// ===== design/mms_pkg.sv =====
// Shared types and constants for the small matrix multiplier.
`default_nettype none

package mms_pkg;

	localparam int ELEM_W    = 32;
	localparam int PROD_W    = 64;
	localparam int FRAC_BITS = 16;
	localparam int CFG_W     = 3;
	localparam int CIDX_W    = 2;
	localparam int OIDX_W    = 2;

	typedef enum logic [CIDX_W-1:0] {
		CFG_ROWS_A    = 2'd0,
		CFG_INNER_DIM = 2'd1,
		CFG_COLS_B    = 2'd2
	} cfg_reg_t;

	typedef enum logic [1:0] {
		ST_LOAD,
		ST_ISSUE,
		ST_DRAIN
	} mms_state_t;

	// Control that travels down the cell chain beside each partial sum.
	typedef struct packed {
		logic valid;
		logic last;
	} mms_tag_t;

endpackage

`default_nettype wire

// ===== design/mms_cell.sv =====
// One multiply-accumulate cell of the chain, holding one column of A and one row of B.
`default_nettype none

module mms_cell #(
	parameter int MAX_DIM = 4,
	parameter int IW      = 2,
	parameter int SUM_W   = 66
) (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire                               wr_a,
	input  wire                               wr_b,
	input  wire        [IW-1:0]               wr_addr,
	input  wire        [mms_pkg::ELEM_W-1:0]  wr_data,
	input  wire                               active,
	input  wire mms_pkg::mms_tag_t            in_tag,
	input  wire        [IW-1:0]               in_row,
	input  wire        [IW-1:0]               in_col,
	input  wire signed [SUM_W-1:0]            in_sum,
	output mms_pkg::mms_tag_t                 out_tag,
	output logic       [IW-1:0]               out_row,
	output logic       [IW-1:0]               out_col,
	output logic signed [SUM_W-1:0]           out_sum
);

	logic signed [mms_pkg::ELEM_W-1:0] a_q [MAX_DIM];
	logic signed [mms_pkg::ELEM_W-1:0] b_q [MAX_DIM];

	logic signed [mms_pkg::ELEM_W-1:0] a_rd;
	logic signed [mms_pkg::ELEM_W-1:0] b_rd;
	logic signed [mms_pkg::PROD_W-1:0] prod;

	mms_pkg::mms_tag_t                 tag_s1;
	logic        [IW-1:0]              row_s1;
	logic        [IW-1:0]              col_s1;
	logic signed [SUM_W-1:0]           sum_s1;
	logic signed [mms_pkg::PROD_W-1:0] prod_s1;

	always_ff @(posedge clk) begin
		if (wr_a) begin
			a_q[wr_addr] <= wr_data;
		end
		if (wr_b) begin
			b_q[wr_addr] <= wr_data;
		end
	end

	assign a_rd = a_q[in_row];
	assign b_rd = b_q[in_col];
	assign prod = mms_pkg::PROD_W'(a_rd) * mms_pkg::PROD_W'(b_rd);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1  <= '0;
			out_tag <= '0;
		end else begin
			tag_s1  <= in_tag;
			out_tag <= tag_s1;
		end
	end

	always_ff @(posedge clk) begin
		row_s1  <= in_row;
		col_s1  <= in_col;
		sum_s1  <= in_sum;
		prod_s1 <= prod;
		out_row <= row_s1;
		out_col <= col_s1;
		// Cells past the inner dimension only hand the sum along.
		out_sum <= active ? (sum_s1 + SUM_W'(prod_s1)) : sum_s1;
	end

endmodule

`default_nettype wire

// ===== design/matrix_multiply_small.sv =====
// Top level of the small Q16.16 matrix multiplier: load control, cell chain and output stage.
// Loading takes one element per cycle with busy low; the last element of B raises busy.
// Product positions then pass the registers of every cell of the chain and the output register,
// and results leave one per cycle; busy stays high until the last result has been shown.
// The receiver cannot stall: every result is shown for exactly one cycle by product_valid.
// Reset (arst_n low) sets all three dimensions to 4 and restarts the load at A; the stores keep
// whatever they held.
`default_nettype none

module matrix_multiply_small #(
	parameter int MAX_DIM = 4
) (
	input  wire                                clk,
	input  wire                                arst_n,
	input  wire                                start,
	output logic                               busy,
	input  wire signed [mms_pkg::ELEM_W-1:0]   element_value,
	input  wire                                cfg_valid,
	output logic                               cfg_ready,
	input  wire        [mms_pkg::CIDX_W-1:0]   cfg_index,
	input  wire        [mms_pkg::CFG_W-1:0]    cfg_data,
	output logic                               product_valid,
	output logic signed [mms_pkg::ELEM_W-1:0]  product_value,
	output logic       [mms_pkg::OIDX_W-1:0]   row_index,
	output logic       [mms_pkg::OIDX_W-1:0]   col_index,
	output logic                               saturated,
	output logic                               last
);

	localparam int IW     = $clog2(MAX_DIM);
	localparam int DIM_W  = $clog2(MAX_DIM + 1);
	localparam int SUM_W  = mms_pkg::PROD_W + $clog2(MAX_DIM);
	localparam int CFG_W  = mms_pkg::CFG_W;
	localparam int ELEM_W = mms_pkg::ELEM_W;
	localparam int FRAC   = mms_pkg::FRAC_BITS;

	// A dimension of zero counts as one, and one above MAX_DIM counts as MAX_DIM.
	function automatic logic [DIM_W-1:0] dim_eff(input logic [CFG_W-1:0] v);
		logic [CFG_W:0] ext;
		ext = {1'b0, v};
		if (v == '0) begin
			dim_eff = DIM_W'(1);
		end else if (ext > (CFG_W + 1)'(MAX_DIM)) begin
			dim_eff = DIM_W'(MAX_DIM);
		end else begin
			dim_eff = DIM_W'(v);
		end
	endfunction

	logic [CFG_W-1:0] rows_a_q;
	logic [CFG_W-1:0] inner_dim_q;
	logic [CFG_W-1:0] cols_b_q;
	logic [DIM_W-1:0] dim_ra;
	logic [DIM_W-1:0] dim_n;
	logic [DIM_W-1:0] dim_cb;

	mms_pkg::mms_state_t state_q;
	mms_pkg::mms_state_t state_d;

	// Load position: ld_b_q selects matrix B, row and column walk in row-major order.
	logic          ld_b_q;
	logic [IW-1:0] ld_row_q;
	logic [IW-1:0] ld_col_q;
	logic [DIM_W-1:0] col_lim;
	logic [DIM_W-1:0] row_lim;
	logic          ld_col_end;
	logic          ld_row_end;
	logic          accept;
	logic          cfg_write;
	logic          cfg_known;

	logic [IW-1:0] iss_row_q;
	logic [IW-1:0] iss_col_q;
	logic          iss_col_end;
	logic          iss_row_end;
	logic          issue_valid;

	logic [MAX_DIM-1:0] wr_a;
	logic [MAX_DIM-1:0] wr_b;
	logic [IW-1:0]      wr_addr;

	mms_pkg::mms_tag_t       tag_c [MAX_DIM+1];
	logic [IW-1:0]           row_c [MAX_DIM+1];
	logic [IW-1:0]           col_c [MAX_DIM+1];
	logic signed [SUM_W-1:0] sum_c [MAX_DIM+1];

	logic signed [SUM_W-1:0] fin_sum;
	logic                    fin_sat;

	assign dim_ra = dim_eff(rows_a_q);
	assign dim_n  = dim_eff(inner_dim_q);
	assign dim_cb = dim_eff(cols_b_q);

	// A register write waits while an element request is offered, so the two never land on
	// the same edge and the element is never dropped by the load restart.
	assign busy      = (state_q != mms_pkg::ST_LOAD);
	assign cfg_ready = !busy && !start;
	assign accept    = start && !busy;
	assign cfg_write = cfg_valid && cfg_ready;
	assign cfg_known = (cfg_index == mms_pkg::CFG_ROWS_A) ||
	                   (cfg_index == mms_pkg::CFG_INNER_DIM) ||
	                   (cfg_index == mms_pkg::CFG_COLS_B);

	// Register writes. Any write to a known register restarts the load at A.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_a_q    <= CFG_W'(4);
			inner_dim_q <= CFG_W'(4);
			cols_b_q    <= CFG_W'(4);
		end else if (cfg_write) begin
			case (cfg_index)
				mms_pkg::CFG_ROWS_A:    rows_a_q    <= cfg_data;
				mms_pkg::CFG_INNER_DIM: inner_dim_q <= cfg_data;
				mms_pkg::CFG_COLS_B:    cols_b_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	// A is rows_a by inner_dim, B is inner_dim by cols_b.
	assign col_lim    = ld_b_q ? dim_cb : dim_n;
	assign row_lim    = ld_b_q ? dim_n : dim_ra;
	assign ld_col_end = (DIM_W'(ld_col_q) + DIM_W'(1)) == col_lim;
	assign ld_row_end = (DIM_W'(ld_row_q) + DIM_W'(1)) == row_lim;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ld_b_q   <= 1'b0;
			ld_row_q <= '0;
			ld_col_q <= '0;
		end else if (cfg_write && cfg_known) begin
			ld_b_q   <= 1'b0;
			ld_row_q <= '0;
			ld_col_q <= '0;
		end else if (accept) begin
			if (ld_col_end) begin
				ld_col_q <= '0;
				if (ld_row_end) begin
					ld_row_q <= '0;
					ld_b_q   <= !ld_b_q;
				end else begin
					ld_row_q <= ld_row_q + IW'(1);
				end
			end else begin
				ld_col_q <= ld_col_q + IW'(1);
			end
		end
	end

	// Element A[r][k] goes to cell k at row r; element B[k][c] goes to cell k at column c.
	assign wr_addr = ld_b_q ? ld_col_q : ld_row_q;

	always_comb begin
		for (int k = 0; k < MAX_DIM; k++) begin
			wr_a[k] = accept && !ld_b_q && (ld_col_q == IW'(k));
			wr_b[k] = accept && ld_b_q && (ld_row_q == IW'(k));
		end
	end

	// The sequencer feeds one product position per cycle into the head of the chain.
	assign iss_col_end = (DIM_W'(iss_col_q) + DIM_W'(1)) == dim_cb;
	assign iss_row_end = (DIM_W'(iss_row_q) + DIM_W'(1)) == dim_ra;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mms_pkg::ST_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		issue_valid = 1'b0;
		case (state_q)
			mms_pkg::ST_LOAD: begin
				if (accept && ld_b_q && ld_col_end && ld_row_end) begin
					state_d = mms_pkg::ST_ISSUE;
				end
			end
			mms_pkg::ST_ISSUE: begin
				issue_valid = 1'b1;
				if (iss_col_end && iss_row_end) begin
					state_d = mms_pkg::ST_DRAIN;
				end
			end
			mms_pkg::ST_DRAIN: begin
				// Busy drops only after the final result has been shown.
				if (product_valid && last) begin
					state_d = mms_pkg::ST_LOAD;
				end
			end
			default: state_d = mms_pkg::ST_LOAD;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iss_row_q <= '0;
			iss_col_q <= '0;
		end else if (issue_valid) begin
			if (iss_col_end) begin
				iss_col_q <= '0;
				iss_row_q <= iss_row_end ? '0 : (iss_row_q + IW'(1));
			end else begin
				iss_col_q <= iss_col_q + IW'(1);
			end
		end
	end

	assign tag_c[0].valid = issue_valid;
	assign tag_c[0].last  = issue_valid && iss_col_end && iss_row_end;
	assign row_c[0]       = iss_row_q;
	assign col_c[0]       = iss_col_q;
	assign sum_c[0]       = '0;

	// Cell k adds A[r][k]*B[k][c] to the partial sum it receives; cells at or past the
	// inner dimension pass it on untouched.
	for (genvar k = 0; k < MAX_DIM; k++) begin : g_cell
		mms_cell #(
			.MAX_DIM (MAX_DIM),
			.IW      (IW),
			.SUM_W   (SUM_W)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.wr_a    (wr_a[k]),
			.wr_b    (wr_b[k]),
			.wr_addr (wr_addr),
			.wr_data (element_value),
			.active  (DIM_W'(k) < dim_n),
			.in_tag  (tag_c[k]),
			.in_row  (row_c[k]),
			.in_col  (col_c[k]),
			.in_sum  (sum_c[k]),
			.out_tag (tag_c[k+1]),
			.out_row (row_c[k+1]),
			.out_col (col_c[k+1]),
			.out_sum (sum_c[k+1])
		);
	end

	// Dropping the 16 low bits rounds toward minus infinity. The result fits in 32 bits
	// only when every bit from bit 31 of the shifted value upward matches the sign.
	assign fin_sum = sum_c[MAX_DIM];
	assign fin_sat = !((&fin_sum[SUM_W-1:FRAC+ELEM_W-1]) || !(|fin_sum[SUM_W-1:FRAC+ELEM_W-1]));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			product_valid <= 1'b0;
			last          <= 1'b0;
		end else begin
			product_valid <= tag_c[MAX_DIM].valid;
			last          <= tag_c[MAX_DIM].valid && tag_c[MAX_DIM].last;
		end
	end

	always_ff @(posedge clk) begin
		row_index <= mms_pkg::OIDX_W'(row_c[MAX_DIM]);
		col_index <= mms_pkg::OIDX_W'(col_c[MAX_DIM]);
		saturated <= fin_sat;
		if (fin_sat) begin
			product_value <= fin_sum[SUM_W-1] ? {1'b1, {(ELEM_W-1){1'b0}}}
			                                  : {1'b0, {(ELEM_W-1){1'b1}}};
		end else begin
			product_value <= fin_sum[FRAC+ELEM_W-1:FRAC];
		end
	end

endmodule

`default_nettype wire

// ===== design/mms_checker.sv =====
// Port-level checks on the matrix multiplier's request and result timing, with its bind.
`default_nettype none

module mms_port_checks (
	input wire clk,
	input wire arst_n,
	input wire start,
	input wire busy,
	input wire cfg_ready,
	input wire product_valid,
	input wire last
);

	// Results appear only while a product is being worked out.
	a_result_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		product_valid |-> busy)
		else $error("result strobe while not busy");

	// Results of one product come out in one unbroken run.
	a_results_contiguous: assert property (@(posedge clk) disable iff (!arst_n)
		(product_valid && !last) |=> product_valid)
		else $error("gap in the run of results");

	// The final result frees the block in the next cycle.
	a_last_frees: assert property (@(posedge clk) disable iff (!arst_n)
		(product_valid && last) |=> !busy)
		else $error("busy held after the final result");

	// Busy ends only right after a final result.
	a_busy_falls_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> $past(product_valid && last))
		else $error("busy dropped without a final result");

	// Register writes are refused while busy or while an element request is offered.
	a_cfg_refused_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(busy || start) |-> !cfg_ready)
		else $error("configuration taken while busy or beside a request");

endmodule

bind matrix_multiply_small mms_port_checks u_port_checks (
	.clk           (clk),
	.arst_n        (arst_n),
	.start         (start),
	.busy          (busy),
	.cfg_ready     (cfg_ready),
	.product_valid (product_valid),
	.last          (last)
);

`default_nettype wire

// ===== dv/mms_checker.sv =====
// Checker for the small matrix multiplier: follows loads and register writes, predicts every product.
module mms_checker #(
	parameter int MAX_DIM = 4
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic                              busy,
	input  logic signed [mms_pkg::ELEM_W-1:0] element_value,
	input  logic                              cfg_valid,
	input  logic                              cfg_ready,
	input  logic        [mms_pkg::CIDX_W-1:0] cfg_index,
	input  logic        [mms_pkg::CFG_W-1:0]  cfg_data,
	input  logic                              product_valid,
	input  logic signed [mms_pkg::ELEM_W-1:0] product_value,
	input  logic        [mms_pkg::OIDX_W-1:0] row_index,
	input  logic        [mms_pkg::OIDX_W-1:0] col_index,
	input  logic                              saturated,
	input  logic                              last,
	output int                                fail_count,
	output int                                outstanding
);

	localparam int ELEM_W    = mms_pkg::ELEM_W;
	localparam int PROD_W    = mms_pkg::PROD_W;
	localparam int FRAC_BITS = mms_pkg::FRAC_BITS;
	localparam int CFG_W     = mms_pkg::CFG_W;
	localparam int OIDX_W    = mms_pkg::OIDX_W;

	localparam int ACC_W = PROD_W + 4;
	localparam logic signed [ACC_W-1:0] Q_MAX = 2147483647;
	localparam logic signed [ACC_W-1:0] Q_MIN = -Q_MAX - 1;
	localparam logic [CFG_W-1:0] DIM_AT_RESET = 3'd4;

	typedef struct {
		logic signed [ELEM_W-1:0] value;
		logic [OIDX_W-1:0]        row;
		logic [OIDX_W-1:0]        col;
		logic                     sat;
		logic                     last;
	} product_t;

	logic [CFG_W-1:0]         rows_cfg;
	logic [CFG_W-1:0]         inner_cfg;
	logic [CFG_W-1:0]         cols_cfg;
	int                       load_pos;
	logic signed [ELEM_W-1:0] a_cells [MAX_DIM][MAX_DIM];
	logic signed [ELEM_W-1:0] b_cells [MAX_DIM][MAX_DIM];
	product_t                 pending_products [$];
	int                       mismatches;

	assign fail_count = mismatches + outstanding;

	// A register value of zero acts as one; anything above the array size acts as the size.
	function automatic int span(input logic [CFG_W-1:0] reg_value);
		if (reg_value == '0)
			return 1;
		if (int'(reg_value) > MAX_DIM)
			return MAX_DIM;
		return int'(reg_value);
	endfunction

	task automatic form_products(input int ra, input int n, input int cb);
		product_t                 p;
		logic signed [ACC_W-1:0]  acc;
		logic signed [PROD_W-1:0] term;
		for (int r = 0; r < ra; r++) begin
			for (int c = 0; c < cb; c++) begin
				acc = '0;
				for (int k = 0; k < n; k++) begin
					term = a_cells[r][k] * b_cells[k][c];
					acc += term;
				end
				// Dropping the low fraction bits of the Q36.32 sum rounds toward minus infinity.
				acc = acc >>> FRAC_BITS;
				p.sat = 1'b1;
				if (acc > Q_MAX) begin
					p.value = ELEM_W'(Q_MAX);
				end else if (acc < Q_MIN) begin
					p.value = ELEM_W'(Q_MIN);
				end else begin
					p.value = acc[ELEM_W-1:0];
					p.sat = 1'b0;
				end
				p.row = OIDX_W'(r);
				p.col = OIDX_W'(c);
				p.last = (r == ra - 1) && (c == cb - 1);
				pending_products.push_back(p);
			end
		end
	endtask

	task automatic take_element();
		int ra, n, cb, a_len, total, pos, j;
		ra = span(rows_cfg);
		n = span(inner_cfg);
		cb = span(cols_cfg);
		a_len = ra * n;
		total = a_len + n * cb;
		pos = (load_pos >= total) ? 0 : load_pos;
		if (pos < a_len) begin
			a_cells[pos / n][pos % n] = element_value;
		end else begin
			j = pos - a_len;
			b_cells[j / cb][j % cb] = element_value;
		end
		pos++;
		if (pos < total) begin
			load_pos = pos;
		end else begin
			load_pos = 0;
			form_products(ra, n, cb);
		end
	endtask

	task automatic check_product();
		product_t want;
		if (pending_products.size() == 0) begin
			$error("product at row %0d col %0d with nothing pending", row_index, col_index);
			mismatches++;
		end else begin
			want = pending_products.pop_front();
			if (product_value !== want.value) begin
				$error("product_value: expected %0d, got %0d", want.value, product_value);
				mismatches++;
			end
			if (row_index !== want.row) begin
				$error("row_index: expected %0d, got %0d", want.row, row_index);
				mismatches++;
			end
			if (col_index !== want.col) begin
				$error("col_index: expected %0d, got %0d", want.col, col_index);
				mismatches++;
			end
			if (saturated !== want.sat) begin
				$error("saturated: expected %0b, got %0b", want.sat, saturated);
				mismatches++;
			end
			if (last !== want.last) begin
				$error("last: expected %0b, got %0b", want.last, last);
				mismatches++;
			end
		end
	endtask

	// Any write to a known register restarts the load at the first element of A.
	task automatic apply_write();
		case (cfg_index)
			mms_pkg::CFG_ROWS_A: begin
				rows_cfg = cfg_data;
				load_pos = 0;
			end
			mms_pkg::CFG_INNER_DIM: begin
				inner_cfg = cfg_data;
				load_pos = 0;
			end
			mms_pkg::CFG_COLS_B: begin
				cols_cfg = cfg_data;
				load_pos = 0;
			end
			default: ;
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_cfg = DIM_AT_RESET;
			inner_cfg = DIM_AT_RESET;
			cols_cfg = DIM_AT_RESET;
			load_pos = 0;
			pending_products.delete();
			outstanding <= 0;
		end else begin
			if (product_valid === 1'b1)
				check_product();
			if (cfg_valid === 1'b1 && cfg_ready === 1'b1)
				apply_write();
			if (start === 1'b1 && busy === 1'b0)
				take_element();
			outstanding <= pending_products.size();
		end
	end

endmodule

// ===== dv/tb_matrix_multiply_small.sv =====
// Testbench top for the small matrix multiplier: element and register stimulus, watchdog, verdict.
module tb_matrix_multiply_small;

	localparam int ELEM_W = mms_pkg::ELEM_W;
	localparam int CFG_W  = mms_pkg::CFG_W;
	localparam int CIDX_W = mms_pkg::CIDX_W;
	localparam int OIDX_W = mms_pkg::OIDX_W;

	localparam int MAX_DIM = 4;
	// Roughly how many element requests the run sends before it winds down.
	localparam int ITEM_TARGET = 430;
	// This outlasts the pass through the cell chain and output stage, so it covers the
	// tail of the cell chain after busy drops and the last product has been seen.
	localparam int SETTLE_CYCLES = 2 * MAX_DIM + 4;
	// The longest correct quiet stretch is the largest request gap plus the settle pause and
	// the time through the cell chain; this allows many times that.
	localparam int QUIET_LIMIT = 2000;
	localparam int MAX_GAP = 13;

	// The index port has room for one register that does not exist; writes to it are dropped.
	localparam logic [CIDX_W-1:0] CFG_SPARE = 2'd3;

	localparam logic signed [ELEM_W-1:0] Q_MAX_ELEM = 32'sh7FFF_FFFF;
	localparam logic signed [ELEM_W-1:0] Q_MIN_ELEM = 32'sh8000_0000;
	localparam logic signed [ELEM_W-1:0] Q_ONE      = 32'sh0001_0000;
	localparam logic signed [ELEM_W-1:0] Q_LSB      = 32'sd1;
	localparam logic signed [ELEM_W-1:0] Q_NEG_LSB  = -32'sd1;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     start = 1'b0;
	logic signed [ELEM_W-1:0] element_value = '0;
	logic                     cfg_valid = 1'b0;
	logic [CIDX_W-1:0]        cfg_index = '0;
	logic [CFG_W-1:0]         cfg_data = '0;

	logic                     busy;
	logic                     cfg_ready;
	logic                     product_valid;
	logic signed [ELEM_W-1:0] product_value;
	logic [OIDX_W-1:0]        row_index;
	logic [OIDX_W-1:0]        col_index;
	logic                     saturated;
	logic                     last;

	int fail_count;
	int outstanding;

	// When burst is set both request channels run back to back with no idle cycles.
	bit burst = 1'b0;
	int sent_items = 0;
	int quiet_cycles = 0;

	matrix_multiply_small #(
		.MAX_DIM(MAX_DIM)
	) u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.element_value(element_value),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.product_valid(product_valid),
		.product_value(product_value),
		.row_index    (row_index),
		.col_index    (col_index),
		.saturated    (saturated),
		.last         (last)
	);

	// The checker sits beside the block, sees the same pins and owns all prediction.
	mms_checker #(
		.MAX_DIM(MAX_DIM)
	) u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.element_value(element_value),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.product_valid(product_valid),
		.product_value(product_value),
		.row_index    (row_index),
		.col_index    (col_index),
		.saturated    (saturated),
		.last         (last),
		.fail_count   (fail_count),
		.outstanding  (outstanding)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Watchdog: any accepted request, register write or product resets the count. A block
	// that hangs, or stops short of its last product, trips it.
	always @(posedge clk) begin
		if ((start && !busy) || (cfg_valid && cfg_ready) || product_valid)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// Effective dimension the block uses for a register value; the testbench needs it only to
	// know how many elements make up a full load.
	function automatic int span(input logic [CFG_W-1:0] reg_value);
		if (reg_value == '0)
			return 1;
		if (int'(reg_value) > MAX_DIM)
			return MAX_DIM;
		return int'(reg_value);
	endfunction

	// Register values favor the ends of the range: zero and seven fall outside the legal
	// dimensions and get clamped, one and four are the legal extremes.
	function automatic logic [CFG_W-1:0] pick_dim();
		case ($urandom_range(0, 7))
			0: return 3'd0;
			1: return 3'd7;
			2: return 3'd1;
			3: return 3'd4;
			default: return CFG_W'($urandom_range(0, 7));
		endcase
	endfunction

	// Element values come in three flavors. Small values, within about eight in Q16.16, keep
	// sums in range and exercise the fraction truncation. Full 32 bit random words toggle every
	// bit and mostly saturate. The corner values hit the signed extremes and unit steps.
	// A heavy load leaves out the small flavor so that saturation shows up often.
	function automatic logic signed [ELEM_W-1:0] pick_element(input bit heavy);
		int flavor;
		flavor = heavy ? $urandom_range(4, 9) : $urandom_range(0, 9);
		if (flavor < 4)
			return ELEM_W'($urandom_range(0, 20'hF_FFFF)) - 32'sh0008_0000;
		if (flavor < 8)
			return ELEM_W'($urandom);
		case ($urandom_range(0, 5))
			0: return Q_MAX_ELEM;
			1: return Q_MIN_ELEM;
			2: return '0;
			3: return Q_NEG_LSB;
			4: return Q_ONE;
			default: return -Q_ONE;
		endcase
	endfunction

	// Sends one element request. Start is held high between back-to-back requests so that it
	// never gets two assignments in one time step; it drops only when a gap is drawn.
	task automatic send_element(input logic signed [ELEM_W-1:0] v);
		int gap;
		gap = burst ? 0 : $urandom_range(0, MAX_GAP);
		if (gap != 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		element_value <= v;
		do @(posedge clk); while (busy);
		sent_items++;
	endtask

	task automatic send_random(input int count, input bit heavy);
		repeat (count) send_element(pick_element(heavy));
	endtask

	// One register write request. As with start, valid stays high across back-to-back writes;
	// the caller lowers it after the last one.
	task automatic write_reg(input logic [CIDX_W-1:0] idx, input logic [CFG_W-1:0] data);
		int gap;
		gap = burst ? 0 : $urandom_range(0, MAX_GAP);
		if (gap != 0) begin
			cfg_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
	endtask

	// Writes all three dimensions, and now and then a write to the unused index as well.
	task automatic configure(input logic [CFG_W-1:0] rv, input logic [CFG_W-1:0] nv,
		input logic [CFG_W-1:0] cv, input bit add_spare);
		write_reg(mms_pkg::CFG_ROWS_A, rv);
		write_reg(mms_pkg::CFG_INNER_DIM, nv);
		write_reg(mms_pkg::CFG_COLS_B, cv);
		if (add_spare)
			write_reg(CFG_SPARE, CFG_W'($urandom));
		cfg_valid <= 1'b0;
	endtask

	// Brings the block to rest: no more requests, every predicted product seen, busy low, and
	// then the chain latency once more in case a load ended without any product due. The first
	// wait always crosses a clock edge, so the checker's count already includes the request
	// that was accepted at the edge just before this call.
	task automatic settle();
		start <= 1'b0;
		do @(posedge clk); while (outstanding != 0 || busy);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	initial begin
		logic [CFG_W-1:0] rv, nv, cv;
		int               load_len;
		int               loads;
		bit               heavy;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part. One by one by one products make each element pair visible on
		// its own: the largest positive square, the most negative square, the most negative
		// cross product, and the smallest negative product, which must floor to minus one LSB.
		configure(3'd1, 3'd1, 3'd1, 1'b0);
		send_element(Q_MAX_ELEM);
		send_element(Q_MAX_ELEM);
		send_element(Q_MIN_ELEM);
		send_element(Q_MIN_ELEM);
		send_element(Q_MIN_ELEM);
		send_element(Q_MAX_ELEM);
		send_element(Q_NEG_LSB);
		send_element(Q_LSB);
		settle();

		// Zero and seven are out of range: this is a one by four times four by one product.
		// Part way through A, a write to the unused index must leave the load where it is, so
		// the remaining five elements complete it.
		configure(3'd0, 3'd7, 3'd0, 1'b0);
		send_random(3, 1'b0);
		settle();
		write_reg(CFG_SPARE, 3'd5);
		cfg_valid <= 1'b0;
		send_random(5, 1'b0);
		settle();

		// A partial load left behind; the register writes that open the random part must
		// throw it away and restart at the first element of A.
		send_random(2, 1'b1);
		settle();

		// Random part. Each phase programs new dimensions and runs a few full loads. Some
		// loads are cut short, which ends the phase so that the next register write lands in
		// the middle of a load. About a third of the phases run with no idle cycles at all.
		while (sent_items < ITEM_TARGET) begin
			burst = ($urandom_range(0, 2) == 0);
			rv = pick_dim();
			nv = pick_dim();
			cv = pick_dim();
			configure(rv, nv, cv, $urandom_range(0, 3) == 0);
			load_len = span(rv) * span(nv) + span(nv) * span(cv);
			loads = $urandom_range(1, 3);
			for (int i = 0; i < loads; i++) begin
				heavy = ($urandom_range(0, 3) == 0);
				if ($urandom_range(0, 6) == 0) begin
					send_random($urandom_range(1, load_len - 1), heavy);
					break;
				end
				send_random(load_len, heavy);
			end
			settle();
		end

		// Everything has been sent and settle() has drained the products, so the count from
		// the checker is final: mismatches, products nobody predicted, and leftovers.
		if (fail_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
